// ----- hw/rtl/pcx_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// PCX run-length rectangle decoder package
// Shared types and constants for the decoder's controller, datapath and
// register block.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

  localparam logic [7:0] RUN_MASK    = 8'hC0;
  localparam logic [7:0] COUNT_MASK  = 8'h3F;
  localparam int         CountWidth  = 6;
  localparam int         PixelsWidth = 16;
  localparam int         PosWidth    = 9;
  localparam int         PaddrWidth  = 3;

  localparam logic REG_ORIGIN_COLUMN = 1'b0;
  localparam logic REG_ORIGIN_ROW    = 1'b1;

  typedef enum logic [2:0] {
    ST_WIDTH,
    ST_HEIGHT,
    ST_CODE,
    ST_VALUE,
    ST_EMIT,
    ST_IDLE
  } ctrl_state_e;

  typedef struct packed {
    logic ld_width;
    logic ld_height;
    logic ld_count;
    logic step_in;
    logic step_lit;
    logic step_work;
  } dp_cmd_t;

  typedef struct packed {
    logic work_done;
    logic image_end;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] origin_column;
    logic [7:0] origin_row;
  } cfg_t;

endpackage

// ----- hw/rtl/pcx_in_if.sv -----
// ----------------------------------------------------------------------------
// PCX decoder input channel
// Valid/ready channel that carries one encoded stream byte per word.
// ----------------------------------------------------------------------------
interface pcx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink (input valid, input data_byte, input image_start, output ready);
endinterface

// ----- hw/rtl/pcx_out_if.sv -----
// ----------------------------------------------------------------------------
// PCX decoder output channel
// Valid/ready channel that carries one screen write per word.
// ----------------------------------------------------------------------------
interface pcx_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] screen_row;
  logic [8:0] screen_column;
  logic [7:0] pixel_byte;
  logic       last_of_run;
  logic       image_done;

  modport source (
    output valid, output screen_row, output screen_column, output pixel_byte,
    output last_of_run, output image_done, input ready
  );
  modport sink (
    input valid, input screen_row, input screen_column, input pixel_byte,
    input last_of_run, input image_done, output ready
  );
endinterface

// ----- hw/rtl/pcx_rle_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// PCX decoder register block
// APB-style access to the origin column and origin row registers.
// ----------------------------------------------------------------------------
module pcx_rle_cfg_regs
  import pcx_rle_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [7:0] origin_column_q;
  logic [7:0] origin_row_q;
  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_column_q <= 8'd0;
      origin_row_q    <= 8'd0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ORIGIN_COLUMN: origin_column_q <= pwdata[7:0];
        REG_ORIGIN_ROW:    origin_row_q    <= pwdata[7:0];
        default:           origin_row_q    <= origin_row_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ORIGIN_COLUMN: prdata = {24'd0, origin_column_q};
      REG_ORIGIN_ROW:    prdata = {24'd0, origin_row_q};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o.origin_column = origin_column_q;
  assign cfg_o.origin_row    = origin_row_q;

endmodule

// ----- hw/rtl/pcx_rle_ctrl.sv -----
// ----------------------------------------------------------------------------
// PCX decoder controller
// Tracks the stream phase and issues load and emit commands to the datapath.
// ----------------------------------------------------------------------------
module pcx_rle_ctrl
  import pcx_rle_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       image_start_i,
  input  logic [1:0] code_top_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q;
  ctrl_state_e state_d;
  ctrl_state_e eff_state;
  logic        accept;
  logic        is_run;
  ctrl_state_e after_emit;

  assign in_ready_o = (state_q != ST_EMIT);
  assign accept     = in_valid_i & in_ready_o;
  assign is_run     = (code_top_i == RUN_MASK[7:6]);
  assign eff_state  = image_start_i ? ST_WIDTH : state_q;
  assign after_emit = status_i.image_end ? ST_IDLE : ST_CODE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WIDTH;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    if (state_q == ST_EMIT) begin
      cmd_o.step_work = 1'b1;
      if (status_i.work_done) begin
        state_d = after_emit;
      end
    end else if (accept) begin
      unique case (eff_state)
        ST_WIDTH: begin
          cmd_o.ld_width = 1'b1;
          state_d        = ST_HEIGHT;
        end
        ST_HEIGHT: begin
          cmd_o.ld_height = 1'b1;
          state_d         = ST_CODE;
        end
        ST_CODE: begin
          if (is_run) begin
            cmd_o.ld_count = 1'b1;
            state_d        = ST_VALUE;
          end else begin
            cmd_o.step_in  = 1'b1;
            cmd_o.step_lit = 1'b1;
            state_d        = status_i.work_done ? after_emit : ST_EMIT;
          end
        end
        ST_VALUE: begin
          cmd_o.step_in = 1'b1;
          state_d       = status_i.work_done ? after_emit : ST_EMIT;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !(in_valid_i && image_start_i)) |=> state_q == ST_IDLE)
    else $error("decoder left the idle phase without an image start mark");

endmodule

// ----- hw/rtl/pcx_rle_dpath.sv -----
// ----------------------------------------------------------------------------
// PCX decoder datapath
// Holds the image geometry, pixel count, write position and pending run, and
// drives the registered output word.
// ----------------------------------------------------------------------------
module pcx_rle_dpath
  import pcx_rle_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PosWidth-1:0] screen_row_o,
  output logic [PosWidth-1:0] screen_column_o,
  output logic [7:0]          pixel_byte_o,
  output logic                last_of_run_o,
  output logic                image_done_o
);

  logic [7:0]             width_q;
  logic [PixelsWidth-1:0] pixels_q;
  logic [PixelsWidth-1:0] pixels_after;
  logic [PosWidth-1:0]    col_q;
  logic [PosWidth-1:0]    row_q;
  logic [CountWidth-1:0]  cnt_q;
  logic [CountWidth-1:0]  src_cnt;
  logic [CountWidth-1:0]  cnt_after;
  logic [7:0]             val_q;
  logic [7:0]             src_val;
  logic                   active;
  logic                   slot_free;
  logic                   fire;
  logic [PosWidth-1:0]    col_inc;
  logic [PosWidth:0]      edge_col;
  logic                   wrap;
  logic                   out_valid_q;
  logic [PosWidth-1:0]    out_row_q;
  logic [PosWidth-1:0]    out_col_q;
  logic [7:0]             out_byte_q;
  logic                   out_last_q;
  logic                   out_done_q;

  assign active    = cmd_i.step_in | cmd_i.step_work;
  assign src_val   = cmd_i.step_work ? val_q : data_byte_i;
  assign src_cnt   = cmd_i.step_lit ? CountWidth'(1) : cnt_q;
  assign slot_free = ~out_valid_q | out_ready_i;
  assign fire      = active & (src_cnt != '0) & (pixels_q != '0) & slot_free;
  assign cnt_after    = src_cnt - CountWidth'(fire);
  assign pixels_after = pixels_q - PixelsWidth'(fire);

  assign status_o.work_done = (cnt_after == '0) | (pixels_after == '0);
  assign status_o.image_end = (pixels_after == '0);

  assign col_inc  = col_q + PosWidth'(1);
  assign edge_col = (PosWidth+1)'(cfg_i.origin_column) + (PosWidth+1)'(width_q);
  assign wrap     = ({1'b0, col_inc} >= edge_col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd0;
      pixels_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (cmd_i.ld_width) begin
        width_q <= data_byte_i;
      end
      if (cmd_i.ld_height) begin
        pixels_q <= PixelsWidth'(width_q) * PixelsWidth'(data_byte_i);
        col_q    <= PosWidth'(cfg_i.origin_column);
        row_q    <= PosWidth'(cfg_i.origin_row);
      end else if (fire) begin
        pixels_q <= pixels_after;
        if (wrap) begin
          col_q <= PosWidth'(cfg_i.origin_column);
          row_q <= row_q + PosWidth'(1);
        end else begin
          col_q <= col_inc;
        end
      end
      if (cmd_i.ld_count) begin
        cnt_q <= data_byte_i[CountWidth-1:0] & COUNT_MASK[CountWidth-1:0];
      end else if (active) begin
        cnt_q <= cnt_after;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (active) begin
      val_q <= src_val;
    end
    if (fire) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_byte_q <= src_val;
      out_last_q <= status_o.work_done;
      out_done_q <= status_o.image_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= fire | (out_valid_q & ~out_ready_i);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign screen_row_o    = out_row_q;
  assign screen_column_o = out_col_q;
  assign pixel_byte_o    = out_byte_q;
  assign last_of_run_o   = out_last_q;
  assign image_done_o    = out_done_q;

  done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("image completion word not marked as the end of its run");

  no_write_past_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixels_q == '0) |-> !fire)
    else $error("screen write issued after the image was complete");

  count_only_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ld_height |=> pixels_q <= $past(pixels_q))
    else $error("pixel count grew without a new image header");

endmodule

// ----- hw/rtl/pcx_rle_rect_decoder_top.sv -----
// ----------------------------------------------------------------------------
// PCX run-length rectangle decoder
// Decodes a PCX run-length image stream into row/column screen writes that
// fill a rectangle at a programmable origin.
//
//   Channel | Dir | Handshake              | Word
//   in_i    | in  | valid/ready            | data_byte, image_start
//   out_o   | out | valid/ready            | screen_row, screen_column,
//           |     |                        | pixel_byte, last_of_run, image_done
//   apb     | in  | psel/penable, pready=1 | origin_column (0x0), origin_row (0x4)
//
// A header byte, a run code, a literal pixel or a run of zero is taken at once.
// A run value byte is taken at once, with its first write if the output is free;
// the input then holds for the rest of the run, up to 63 writes in all, paced by the single output register.
// A literal is absorbed while the previous word still waits at the output.
// Reset clears the phase, counters and origin registers; there is no sweep.
// Output backpressure stalls the write sequencer without losing words.
// ----------------------------------------------------------------------------
module pcx_rle_rect_decoder_top
  import pcx_rle_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  pcx_in_if.sink                in_i,
  pcx_out_if.source             out_o
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  pcx_rle_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcx_rle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .image_start_i (in_i.image_start),
    .code_top_i    (in_i.data_byte[7:6]),
    .in_ready_o    (in_i.ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  pcx_rle_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .data_byte_i     (in_i.data_byte),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .screen_row_o    (out_o.screen_row),
    .screen_column_o (out_o.screen_column),
    .pixel_byte_o    (out_o.pixel_byte),
    .last_of_run_o   (out_o.last_of_run),
    .image_done_o    (out_o.image_done)
  );

endmodule
